// File: hw/rtl/differential_drive_odometry_unit_assert.svh
// Assertion macros for the odometry unit checker.
// No dependencies; included by the checker file.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_ASSERT_SVH

// check a property on a given clock and active-low reset
`define DDO_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("odometry assertion failed");

// check a property on clk_i and rst_ni
`define DDO_ASSERT(lbl, prop) `DDO_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// File: hw/rtl/ddo_pkg.sv
// Shared types, constants and helpers of the odometry unit.
// No dependencies; used by ddo_div, ddo_cordic and the top level.
package ddo_pkg;

  localparam int CORDIC_STEPS = 16;

  localparam logic [1:0] CFG_TPD = 2'd0;
  localparam logic [1:0] CFG_TW  = 2'd1;

  localparam logic [15:0] TPD_RESET = 16'd7837;
  localparam logic [15:0] TW_RESET  = 16'd1150;

  localparam logic signed [20:0] TWO_PI_Q16  = 21'sd411775;
  localparam logic signed [20:0] PI_Q16      = 21'sd205887;
  localparam logic signed [20:0] HALF_PI_Q16 = 21'sd102944;

  localparam logic signed [33:0] CORDIC_INV_GAIN = 34'sd652032874;
  localparam logic [31:0]        CDEG_PER_RAD    = 32'd375493620;

  localparam logic [31:0] DEN_CENTER = 32'd6250;
  localparam logic [31:0] DEN_TWO_PI = 32'd411775;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MUL_S, ST_DIV_C, ST_WAIT_C, ST_MUL_D, ST_DIV_H, ST_WAIT_H,
    ST_DIV_M, ST_WAIT_M, ST_WAIT_R, ST_MUL_XL, ST_MUL_XH, ST_MUL_YL,
    ST_MUL_YH, ST_UPDATE, ST_FIN, ST_MUL_H, ST_OUT
  } state_e;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;

  function automatic logic signed [31:0] atan_q28(input int idx);
    logic signed [31:0] v;
    case (idx)
      0:  v = 32'sd210828714;
      1:  v = 32'sd124459457;
      2:  v = 32'sd65760959;
      3:  v = 32'sd33381290;
      4:  v = 32'sd16755422;
      5:  v = 32'sd8385879;
      6:  v = 32'sd4193963;
      7:  v = 32'sd2097109;
      8:  v = 32'sd1048571;
      9:  v = 32'sd524287;
      10: v = 32'sd262144;
      11: v = 32'sd131072;
      12: v = 32'sd65536;
      13: v = 32'sd32768;
      14: v = 32'sd16384;
      15: v = 32'sd8192;
      16: v = 32'sd4096;
      17: v = 32'sd2048;
      18: v = 32'sd1024;
      19: v = 32'sd512;
      20: v = 32'sd256;
      21: v = 32'sd128;
      22: v = 32'sd64;
      23: v = 32'sd32;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh7FFFFFFF) r = 32'sh7FFFFFFF;
    else if (v < -64'sh80000000) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [55:0] v);
    logic signed [47:0] r;
    if (v > 56'sh7FFFFFFFFFFF) r = 48'sh7FFFFFFFFFFF;
    else if (v < -56'sh800000000000) r = 48'sh800000000000;
    else r = v[47:0];
    return r;
  endfunction

endpackage

// File: hw/rtl/ddo_req_if.sv
// Encoder sample channel of the odometry unit.
// No dependencies.
interface ddo_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [31:0] left_count;
  logic signed [31:0] right_count;
  modport source (output valid, req_type, left_count, right_count, input ready);
  modport sink (input valid, req_type, left_count, right_count, output ready);
endinterface

// File: hw/rtl/ddo_pose_if.sv
// Pose result channel of the odometry unit.
// No dependencies.
interface ddo_pose_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pose_x_mm;
  logic signed [31:0] pose_y_mm;
  logic signed [31:0] heading_cdeg;
  modport source (output valid, pose_x_mm, pose_y_mm, heading_cdeg, input ready);
  modport sink (input valid, pose_x_mm, pose_y_mm, heading_cdeg, output ready);
endinterface

// File: hw/rtl/ddo_div.sv
// Restoring divider, one quotient bit per cycle, 64 by 32 bits.
// Depends on ddo_pkg.
module ddo_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ddo_pkg::div_req_t req_i,
  output logic              done_o,
  output logic [63:0]       quo_o,
  output logic [31:0]       rem_o
);
  import ddo_pkg::*;

  logic [31:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [31:0] den_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] trial;
  logic [32:0] diff;

  assign trial = {rem_q, quo_q[63]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    if (!diff[32]) begin
      rem_d = diff[31:0];
      quo_d = {quo_q[62:0], 1'b1};
    end else begin
      rem_d = trial[31:0];
      quo_d = {quo_q[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.num;
      den_q <= req_i.den;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
endmodule

// File: hw/rtl/ddo_cordic.sv
// Rotation-mode CORDIC, one micro-rotation per cycle on shared x and y shifters.
// Depends on ddo_pkg.
module ddo_cordic (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [31:0]  z_i,
  output logic                done_o,
  output logic signed [33:0]  x_o,
  output logic signed [33:0]  y_o
);
  import ddo_pkg::*;

  localparam int CW = $clog2(CORDIC_STEPS + 1);

  logic signed [33:0] x_q, y_q, xs, ys;
  logic signed [31:0] z_q, ang;
  logic [CW-1:0]      cnt_q;
  logic               busy_q, done_q;

  assign xs  = x_q >>> cnt_q;
  assign ys  = y_q >>> cnt_q;
  assign ang = atan_q28(int'(cnt_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= CORDIC_INV_GAIN;
      y_q <= '0;
      z_q <= z_i;
    end else if (busy_q) begin
      if (!z_q[31]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - ang;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + ang;
      end
    end
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
endmodule

// File: hw/rtl/differential_drive_odometry_unit.sv
// Top level of the differential-drive odometry unit: sequencer, shared
// multiplier and pose state. Depends on ddo_pkg, ddo_req_if, ddo_pose_if,
// ddo_div and ddo_cordic.
//
//   channel  | dir | payload                                  | handshake
//   req_if   | in  | req_type, left_count, right_count        | valid/ready
//   pose_if  | out | pose_x_mm, pose_y_mm, heading_cdeg       | valid/ready
//   cfg      | in  | cfg_idx_i, cfg_wdata_i                   | cfg_we_i
//
// A priming sample passes only through ST_FIN, ST_MUL_H and ST_OUT. An update
// takes three passes of the bit-serial divider, a CORDIC run and the
// sequencer and multiplier steps around them.
// One item is in work at a time. Reset needs no clearing pass.
// The result register holds a pose until it
// is taken; the next sample is accepted meanwhile, and the unit stalls in
// its last step only if a new pose is ready while the old one still waits.
module differential_drive_odometry_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  ddo_req_if.sink     req_if,
  ddo_pose_if.source  pose_if,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);
  import ddo_pkg::*;

  state_e state_q, state_d;

  logic [15:0] tpd_q, tw_q;
  logic        primed_q, req_q;
  logic signed [31:0] left_q, right_q, prev_l_q, prev_r_q, head_q;
  logic signed [47:0] pos_x_q, pos_y_q;

  logic [48:0] dc_mag_q;
  logic        dc_neg_q;
  logic [53:0] dh_mag_q;
  logic        dh_neg_q;
  logic        mid_neg_q;
  logic        flip_q;
  logic [31:0] cmag_q, smag_q;
  logic        cneg_q, sneg_q;
  logic [66:0] prod_q, prod_d;
  logic [63:0] plo_q;
  logic signed [51:0] mx_q;

  logic        ov_q;
  logic signed [31:0] ox_q, oy_q, oh_q;

  logic signed [32:0] dl, dr;
  logic signed [33:0] sum, diff;
  logic [33:0] sum_mag, diff_mag;
  logic [34:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] den_h;

  div_req_t    div_req;
  logic        div_done;
  logic [63:0] div_quo;
  logic [31:0] div_rem;

  logic        cor_start, cor_done;
  logic signed [33:0] cor_x, cor_y, c_val, s_val;
  logic signed [31:0] z_val;
  logic        flip_d;

  logic signed [55:0] half_s, mid_s;
  logic [55:0] mid_abs;
  logic signed [20:0] r0, r1, r2, r3;
  logic [50:0] m_mag;
  logic signed [51:0] m_s;
  logic signed [52:0] px_sum, py_sum;
  logic signed [55:0] h_sum;
  logic [47:0] px_abs, py_abs;
  logic [32:0] px_r, py_r;
  logic [31:0] head_abs;
  logic [34:0] h_r;
  logic signed [31:0] ox_d, oy_d, oh_d;

  assign dl       = {left_q[31], left_q} - {prev_l_q[31], prev_l_q};
  assign dr       = {right_q[31], right_q} - {prev_r_q[31], prev_r_q};
  assign sum      = {dl[32], dl} + {dr[32], dr};
  assign diff     = {dr[32], dr} - {dl[32], dl};
  assign sum_mag  = sum[33] ? 34'(-sum) : 34'(sum);
  assign diff_mag = diff[33] ? 34'(-diff) : 34'(diff);
  assign den_h    = {16'b0, tw_q} * 32'd625;
  assign head_abs = head_q[31] ? 32'(-head_q) : 32'(head_q);

  assign half_s  = $signed({3'b0, dh_mag_q[53:1]});
  assign mid_s   = {{24{head_q[31]}}, head_q} + (dh_neg_q ? -half_s : half_s);
  assign mid_abs = mid_s[55] ? 56'(-mid_s) : 56'(mid_s);

  assign r0 = mid_neg_q ? -$signed({2'b0, div_rem[18:0]}) : $signed({2'b0, div_rem[18:0]});
  assign r1 = r0[20] ? r0 + TWO_PI_Q16 : r0;
  assign r2 = (r1 > PI_Q16) ? r1 - TWO_PI_Q16 : r1;
  always_comb begin
    if (r2 > HALF_PI_Q16) begin
      r3 = r2 - PI_Q16;
      flip_d = 1'b1;
    end else if (r2 < -HALF_PI_Q16) begin
      r3 = r2 + PI_Q16;
      flip_d = 1'b1;
    end else begin
      r3 = r2;
      flip_d = 1'b0;
    end
  end
  assign z_val = {{11{r3[20]}}, r3} <<< 12;

  assign c_val = flip_q ? -cor_x : cor_x;
  assign s_val = flip_q ? -cor_y : cor_y;

  assign m_mag = {prod_q[48:0], 2'b0} + 51'(({1'b0, plo_q} + 65'd536870912) >> 30);

  always_comb begin
    if (state_q == ST_MUL_YL) m_s = (dc_neg_q ^ cneg_q) ? -$signed({1'b0, m_mag})
                                                          : $signed({1'b0, m_mag});
    else m_s = (dc_neg_q ^ sneg_q) ? -$signed({1'b0, m_mag}) : $signed({1'b0, m_mag});
  end

  assign px_sum = {{5{pos_x_q[47]}}, pos_x_q} + {mx_q[51], mx_q};
  assign py_sum = {{5{pos_y_q[47]}}, pos_y_q} + {m_s[51], m_s};
  assign h_sum  = {{24{head_q[31]}}, head_q}
                + (dh_neg_q ? -$signed({2'b0, dh_mag_q}) : $signed({2'b0, dh_mag_q}));

  assign px_abs = pos_x_q[47] ? 48'(-pos_x_q) : 48'(pos_x_q);
  assign py_abs = pos_y_q[47] ? 48'(-pos_y_q) : 48'(pos_y_q);
  assign px_r   = 33'(({1'b0, px_abs} + 49'd32768) >> 16);
  assign py_r   = 33'(({1'b0, py_abs} + 49'd32768) >> 16);
  assign h_r    = 35'(({1'b0, prod_q} + 68'd2147483648) >> 32);
  assign ox_d = sat32(pos_x_q[47] ? -$signed({31'b0, px_r}) : $signed({31'b0, px_r}));
  assign oy_d = sat32(pos_y_q[47] ? -$signed({31'b0, py_r}) : $signed({31'b0, py_r}));
  assign oh_d = sat32(head_q[31] ? -$signed({29'b0, h_r}) : $signed({29'b0, h_r}));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (req_if.valid) state_d = primed_q ? ST_MUL_S : ST_FIN;
      ST_MUL_S:  state_d = ST_DIV_C;
      ST_DIV_C:  state_d = ST_WAIT_C;
      ST_WAIT_C: if (div_done) state_d = ST_MUL_D;
      ST_MUL_D:  state_d = ST_DIV_H;
      ST_DIV_H:  state_d = ST_WAIT_H;
      ST_WAIT_H: if (div_done) state_d = ST_DIV_M;
      ST_DIV_M:  state_d = ST_WAIT_M;
      ST_WAIT_M: if (div_done) state_d = ST_WAIT_R;
      ST_WAIT_R: if (cor_done) state_d = ST_MUL_XL;
      ST_MUL_XL: state_d = ST_MUL_XH;
      ST_MUL_XH: state_d = ST_MUL_YL;
      ST_MUL_YL: state_d = ST_MUL_YH;
      ST_MUL_YH: state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_FIN;
      ST_FIN:    state_d = ST_MUL_H;
      ST_MUL_H:  state_d = ST_OUT;
      ST_OUT:    if (!ov_q || pose_if.ready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_req.start = 1'b0;
    div_req.num = '0;
    div_req.den = DEN_CENTER;
    cor_start = 1'b0;
    case (state_q)
      ST_MUL_S: begin
        mul_a = {1'b0, sum_mag};
        mul_b = {16'b0, tpd_q};
      end
      ST_MUL_D: begin
        mul_a = {1'b0, diff_mag};
        mul_b = {16'b0, tpd_q};
      end
      ST_MUL_XL: begin
        mul_a = {3'b0, dc_mag_q[31:0]};
        mul_b = cmag_q;
      end
      ST_MUL_XH: begin
        mul_a = {18'b0, dc_mag_q[48:32]};
        mul_b = cmag_q;
      end
      ST_MUL_YL: begin
        mul_a = {3'b0, dc_mag_q[31:0]};
        mul_b = smag_q;
      end
      ST_MUL_YH: begin
        mul_a = {18'b0, dc_mag_q[48:32]};
        mul_b = smag_q;
      end
      ST_MUL_H, ST_OUT: begin
        mul_a = {3'b0, head_abs};
        mul_b = CDEG_PER_RAD;
      end
      ST_DIV_C: begin
        div_req.start = 1'b1;
        div_req.num = {prod_q[52:0], 11'b0} + 64'd3125;
        div_req.den = DEN_CENTER;
      end
      ST_DIV_H: begin
        div_req.start = 1'b1;
        div_req.num = {prod_q[51:0], 12'b0} + {33'b0, den_h[31:1]};
        div_req.den = den_h;
      end
      ST_DIV_M: begin
        div_req.start = 1'b1;
        div_req.num = {8'b0, mid_abs};
        div_req.den = DEN_TWO_PI;
      end
      ST_WAIT_M: cor_start = div_done;
      default: begin
      end
    endcase
  end

  assign prod_d = {32'b0, mul_a} * {35'b0, mul_b};

  ddo_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo),
    .rem_o  (div_rem)
  );

  ddo_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .z_i     (z_val),
    .done_o  (cor_done),
    .x_o     (cor_x),
    .y_o     (cor_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      tpd_q    <= TPD_RESET;
      tw_q     <= TW_RESET;
      primed_q <= 1'b0;
      prev_l_q <= '0;
      prev_r_q <= '0;
      pos_x_q  <= '0;
      pos_y_q  <= '0;
      head_q   <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && cfg_wdata_i != 16'd0) begin
        case (cfg_idx_i)
          CFG_TPD: tpd_q <= cfg_wdata_i;
          CFG_TW:  tw_q  <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (state_q == ST_IDLE && req_if.valid && !primed_q) begin
        primed_q <= 1'b1;
        prev_l_q <= req_if.left_count;
        prev_r_q <= req_if.right_count;
      end
      if (state_q == ST_UPDATE) begin
        prev_l_q <= left_q;
        prev_r_q <= right_q;
        pos_x_q  <= sat48({{3{px_sum[52]}}, px_sum});
        pos_y_q  <= sat48({{3{py_sum[52]}}, py_sum});
        head_q   <= sat32({{8{h_sum[55]}}, h_sum});
      end
      if (state_q == ST_FIN && req_q) begin
        pos_x_q <= '0;
        pos_y_q <= '0;
        head_q  <= '0;
      end
      if (state_q == ST_OUT && (!ov_q || pose_if.ready)) ov_q <= 1'b1;
      else if (pose_if.ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (state_q == ST_IDLE && req_if.valid) begin
      req_q   <= req_if.req_type;
      left_q  <= req_if.left_count;
      right_q <= req_if.right_count;
    end
    if (state_q == ST_WAIT_C && div_done) begin
      dc_neg_q <= sum[33];
      dc_mag_q <= (div_quo > 64'h1_0000_0000_0000) ? 49'h1_0000_0000_0000 : div_quo[48:0];
    end
    if (state_q == ST_WAIT_H && div_done) begin
      dh_neg_q <= diff[33];
      dh_mag_q <= div_quo[53:0];
    end
    if (state_q == ST_DIV_M) mid_neg_q <= mid_s[55];
    if (state_q == ST_WAIT_M && div_done) flip_q <= flip_d;
    if (state_q == ST_WAIT_R && cor_done) begin
      cneg_q <= c_val[33];
      sneg_q <= s_val[33];
      cmag_q <= c_val[33] ? 32'(-c_val) : 32'(c_val);
      smag_q <= s_val[33] ? 32'(-s_val) : 32'(s_val);
    end
    if (state_q == ST_MUL_XH || state_q == ST_MUL_YH) plo_q <= prod_q[63:0];
    if (state_q == ST_MUL_YL) mx_q <= m_s;
    if (state_q == ST_OUT && (!ov_q || pose_if.ready)) begin
      ox_q <= ox_d;
      oy_q <= oy_d;
      oh_q <= oh_d;
    end
  end

  assign req_if.ready         = (state_q == ST_IDLE);
  assign pose_if.valid        = ov_q;
  assign pose_if.pose_x_mm    = ox_q;
  assign pose_if.pose_y_mm    = oy_q;
  assign pose_if.heading_cdeg = oh_q;
endmodule

// File: hw/rtl/ddo_checker.sv
// Port-level checker of the odometry unit and its bind.
// Depends on differential_drive_odometry_unit_assert.svh.
`include "differential_drive_odometry_unit_assert.svh"

module ddo_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_x_i
);
  `DDO_ASSERT(busy_after_transfer, in_valid_i && in_ready_i |=> !in_ready_i)
  `DDO_ASSERT(busy_two_after, in_valid_i && in_ready_i |-> ##2 !in_ready_i)
  `DDO_ASSERT(result_while_busy, $rose(out_valid_i) |-> !$past(in_ready_i))
  `DDO_ASSERT(result_held, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_x_i))
endmodule

bind differential_drive_odometry_unit ddo_checker u_ddo_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_if.valid),
  .in_ready_i  (req_if.ready),
  .out_valid_i (pose_if.valid),
  .out_ready_i (pose_if.ready),
  .out_x_i     (pose_if.pose_x_mm)
);
